// ===== rtl/core/fqd_pkg.sv =====
// Shared types, constants and the arctangent table of the FM quadrature demodulator.
package fqd_pkg;

  // Field and state widths fixed by the data format.
  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 7;
  localparam int TOTAL_W    = 22;
  localparam int DIVISOR_W  = 7;
  localparam int PROD_W     = 33;
  localparam int VEC_W      = 64;
  localparam int ANGLE_W    = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Default configuration and store size.
  localparam int DEF_MAX_BLOCK_SAMPLES = 64;
  localparam logic [7:0] DEF_DECIMATION = 8'd46;

  // Converter arithmetic.
  localparam logic [7:0] BYTE_FULL   = 8'd255;
  localparam logic [8:0] BYTE_CENTRE = 9'd127;

  // Division by ten as a multiply by ceil(2^19 / 10) and a shift; exact for
  // magnitudes below 2^18, which covers every smoothing numerator.
  localparam int SMOOTH_NUM_W = 18;
  localparam int RECIP_W      = 16;
  localparam int SMOOTH_SHIFT = 19;
  localparam logic [RECIP_W-1:0] SMOOTH_RECIP = 16'd52429;

  // Phase results in units of pi/16384.
  localparam logic signed [SAMPLE_W-1:0] PH_ZERO     = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] PH_HALF     = 16'sd16384;
  localparam logic signed [SAMPLE_W-1:0] PH_QUARTER  = 16'sd8192;
  localparam logic signed [SAMPLE_W-1:0] PH_EIGHTH   = 16'sd4096;
  localparam logic signed [SAMPLE_W-1:0] PH_3EIGHTHS = 16'sd12288;

  // CORDIC set-up.
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_SCALE = 28;
  localparam int ANGLE_SHIFT  = 16;
  localparam logic signed [ANGLE_W-1:0] ANGLE_RIGHT = 32'sd536870912;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIMATION = 8'd0,
    CFG_BYPASS     = 8'd1
  } cfg_index_t;

  // Top-level sequencer.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE_GO,
    ST_PHASE_WAIT,
    ST_BLOCK_END,
    ST_AVG_WAIT,
    ST_SMOOTH_GO,
    ST_SMOOTH_WAIT,
    ST_READ,
    ST_EMIT
  } state_t;

  // Phase unit sequencer.
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_CHECK,
    CS_ITER,
    CS_FINISH
  } cordic_state_t;

  // atan(2^-i) in units of pi/2^30, rounded to nearest.
  function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [ANGLE_W-1:0] v;
    unique case (i)
      5'd0:  v = 32'sd268435456;
      5'd1:  v = 32'sd158466703;
      5'd2:  v = 32'sd83729454;
      5'd3:  v = 32'sd42502379;
      5'd4:  v = 32'sd21333666;
      5'd5:  v = 32'sd10677233;
      5'd6:  v = 32'sd5339919;
      5'd7:  v = 32'sd2670123;
      5'd8:  v = 32'sd1335082;
      5'd9:  v = 32'sd667543;
      5'd10: v = 32'sd333772;
      5'd11: v = 32'sd166886;
      5'd12: v = 32'sd83443;
      5'd13: v = 32'sd41722;
      5'd14: v = 32'sd20861;
      5'd15: v = 32'sd10430;
      5'd16: v = 32'sd5215;
      5'd17: v = 32'sd2608;
      5'd18: v = 32'sd1304;
      5'd19: v = 32'sd652;
      5'd20: v = 32'sd326;
      5'd21: v = 32'sd163;
      5'd22: v = 32'sd81;
      5'd23: v = 32'sd41;
      5'd24: v = 32'sd20;
      5'd25: v = 32'sd10;
      5'd26: v = 32'sd5;
      5'd27: v = 32'sd3;
      5'd28: v = 32'sd1;
      5'd29: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/fqd_store.sv =====
// Block sample store: one write port and one registered read port.
module fqd_store #(
  parameter int DEPTH = fqd_pkg::DEF_MAX_BLOCK_SAMPLES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [fqd_pkg::SAMPLE_W-1:0] wdata,
  input  logic                              re,
  input  logic [AW-1:0]                     raddr,
  output logic signed [fqd_pkg::SAMPLE_W-1:0] rdata
);

  logic signed [fqd_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered: the data follows the address in the next cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/fqd_divider.sv =====
// Restoring divider, one quotient bit a cycle, truncating toward zero.
module fqd_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [fqd_pkg::TOTAL_W-1:0]   dividend,
  input  logic [fqd_pkg::DIVISOR_W-1:0]        divisor,
  output logic                                 done,
  output logic signed [fqd_pkg::TOTAL_W-1:0]   quotient
);

  localparam int TW = fqd_pkg::TOTAL_W;
  localparam int DW = fqd_pkg::DIVISOR_W;
  localparam int CW = $clog2(TW + 1);

  logic          busy;
  logic [CW-1:0] steps;
  logic          neg;
  logic [TW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   rem_sh;
  logic [TW-1:0] quo_sh;
  logic [DW:0]   rem_sub;
  logic          fits;

  // One restoring step on the partial remainder.
  always_comb begin
    rem_sh  = {rem, quo[TW-1]};
    quo_sh  = {quo[TW-2:0], 1'b0};
    fits    = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CW'(TW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath on magnitudes.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[TW-1];
      quo <= dividend[TW-1] ? TW'(-dividend) : TW'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= fits ? (quo_sh | TW'(1)) : quo_sh;
      rem <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

// ===== rtl/core/fqd_cordic.sv =====
// Phase step between two complex samples by a vectoring CORDIC, one step a cycle.
module fqd_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [fqd_pkg::SAMPLE_W-1:0]  a_re,
  input  logic signed [fqd_pkg::SAMPLE_W-1:0]  a_im,
  input  logic signed [fqd_pkg::SAMPLE_W-1:0]  b_re,
  input  logic signed [fqd_pkg::SAMPLE_W-1:0]  b_im,
  output logic                                 done,
  output logic signed [fqd_pkg::SAMPLE_W-1:0]  phase
);

  localparam int PW = fqd_pkg::PROD_W;
  localparam int VW = fqd_pkg::VEC_W;
  localparam int AN = fqd_pkg::ANGLE_W;
  localparam int SW = fqd_pkg::SAMPLE_W;

  fqd_pkg::cordic_state_t state, state_next;

  logic [4:0]               step;
  logic [1:0]               mcnt;
  logic signed [PW-1:0]     cr, cj;
  logic signed [SW-1:0]     op_a, op_b;
  logic signed [2*SW-1:0]   prod;
  logic signed [VW-1:0]     x, y, xs, ys, dx, dy;
  logic signed [AN-1:0]     acc, acc_mag;
  logic signed [AN-1:0]     q;
  logic                     special;
  logic signed [SW-1:0]     special_ph;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (mcnt)
      2'd0:    begin op_a = a_re; op_b = b_re; end
      2'd1:    begin op_a = a_im; op_b = b_im; end
      2'd2:    begin op_a = a_im; op_b = b_re; end
      default: begin op_a = a_re; op_b = b_im; end
    endcase
    prod = op_a * op_b;
  end

  // Exact answers on the axes and diagonals.
  always_comb begin
    special    = 1'b1;
    special_ph = fqd_pkg::PH_ZERO;
    if (cj == '0) begin
      special_ph = (cr < 0) ? fqd_pkg::PH_HALF : fqd_pkg::PH_ZERO;
    end else if (cr == '0) begin
      special_ph = (cj > 0) ? fqd_pkg::PH_QUARTER : -fqd_pkg::PH_QUARTER;
    end else if (cj == cr) begin
      special_ph = (cr > 0) ? fqd_pkg::PH_EIGHTH : -fqd_pkg::PH_3EIGHTHS;
    end else if (cj == -cr) begin
      special_ph = (cr > 0) ? -fqd_pkg::PH_EIGHTH : fqd_pkg::PH_3EIGHTHS;
    end else begin
      special = 1'b0;
    end
  end

  // Scaled vector and the CORDIC shifts.
  always_comb begin
    xs      = VW'(cr) <<< fqd_pkg::CORDIC_SCALE;
    ys      = VW'(cj) <<< fqd_pkg::CORDIC_SCALE;
    dx      = y >>> step;
    dy      = x >>> step;
    acc_mag = (acc < 0) ? -acc : acc;
    q       = (acc < 0) ? -(acc_mag >>> fqd_pkg::ANGLE_SHIFT)
                        : (acc_mag >>> fqd_pkg::ANGLE_SHIFT);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fqd_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fqd_pkg::CS_IDLE:   if (start) state_next = fqd_pkg::CS_MUL;
      fqd_pkg::CS_MUL:    if (mcnt == 2'd3) state_next = fqd_pkg::CS_CHECK;
      fqd_pkg::CS_CHECK:  state_next = special ? fqd_pkg::CS_IDLE : fqd_pkg::CS_ITER;
      fqd_pkg::CS_ITER: begin
        if (step == 5'(fqd_pkg::CORDIC_STEPS - 1)) state_next = fqd_pkg::CS_FINISH;
      end
      fqd_pkg::CS_FINISH: state_next = fqd_pkg::CS_IDLE;
      default:            state_next = fqd_pkg::CS_IDLE;
    endcase
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      mcnt <= '0;
      step <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        fqd_pkg::CS_IDLE: begin
          mcnt <= '0;
          step <= '0;
        end
        fqd_pkg::CS_MUL: begin
          mcnt <= mcnt + 1'b1;
          unique case (mcnt)
            2'd0:    cr <= PW'(prod);
            2'd1:    cr <= cr + PW'(prod);
            2'd2:    cj <= PW'(prod);
            default: cj <= cj - PW'(prod);
          endcase
        end
        fqd_pkg::CS_CHECK: begin
          if (special) begin
            phase <= special_ph;
            done  <= 1'b1;
          end else if (cr < 0) begin
            // Quarter turn into the right half-plane.
            if (cj > 0) begin
              x <= ys; y <= -xs; acc <= fqd_pkg::ANGLE_RIGHT;
            end else begin
              x <= -ys; y <= xs; acc <= -fqd_pkg::ANGLE_RIGHT;
            end
          end else begin
            x <= xs; y <= ys; acc <= '0;
          end
        end
        fqd_pkg::CS_ITER: begin
          step <= step + 1'b1;
          if (y > 0) begin
            x   <= x + dx;
            y   <= y - dy;
            acc <= acc + fqd_pkg::atan_entry(step);
          end else begin
            x   <= x - dx;
            y   <= y + dy;
            acc <= acc - fqd_pkg::atan_entry(step);
          end
        end
        fqd_pkg::CS_FINISH: begin
          done <= 1'b1;
          if (q > AN'(fqd_pkg::PH_HALF)) begin
            phase <= fqd_pkg::PH_HALF;
          end else if (q < -AN'(fqd_pkg::PH_HALF)) begin
            phase <= -fqd_pkg::PH_HALF;
          end else begin
            phase <= q[SW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/fm_quadrature_demodulator.sv =====
// Top level of the FM quadrature demodulator: input path, block sequencer and output register.
//
// Each input beat carries one raw I/Q byte pair; a pair that neither closes a
// decimated sample nor ends a block leaves the input open. A pair that closes
// one keeps the input closed while the phase unit runs: the start, four
// products on the shared 16x16 multiplier, the check, thirty CORDIC steps,
// the finishing state and the hand-back; axis and diagonal cases finish after
// the check. At the end of a non-empty block the block average takes a
// 22-step division and the smoothing by ten passes through its SMOOTH_GO and
// SMOOTH_WAIT states, after which the stored samples are read back from the
// block memory and sent one at a time: each is read before it is loaded into
// the output register, and the next read waits out any output stall. An empty
// block end returns straight to accepting input. No input is taken from the
// end of a block until its last sample has been loaded into the output
// register. Reset needs no clearing pass.
module fm_quadrature_demodulator #(
  parameter int MAX_BLOCK_SAMPLES = fqd_pkg::DEF_MAX_BLOCK_SAMPLES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,  // raw_i [7:0], raw_q [15:8]
  input  logic                              s_tlast,  // end_of_block
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,  // audio_sample [15:0]
  output logic                              m_tlast,  // last_of_block
  output logic                              m_tuser,  // block_overflowed
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fqd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fqd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW = fqd_pkg::SAMPLE_W;
  localparam int CW = fqd_pkg::COUNT_W;
  localparam int TW = fqd_pkg::TOTAL_W;
  localparam int NW = fqd_pkg::SMOOTH_NUM_W;
  localparam int RW = fqd_pkg::RECIP_W;
  localparam int AW = (MAX_BLOCK_SAMPLES > 1) ? $clog2(MAX_BLOCK_SAMPLES) : 1;

  fqd_pkg::state_t state, state_next;

  logic [7:0]           factor;
  logic                 bypass;
  logic [1:0]           rot_phase;
  logic [7:0]           dcount;
  logic signed [SW-1:0] sum_i, sum_q, prev_i, prev_q;
  logic signed [SW-1:0] smoothed, avg, offset;
  logic [CW-1:0]        bcount, rd_idx;
  logic signed [TW-1:0] btotal;
  logic                 overflow_seen;
  logic                 eob_hold;

  logic                 accept;
  logic [7:0]           raw_i, raw_q, bi, bq;
  logic [7:0]           dcount_inc;
  logic                 closes;
  logic signed [SW-1:0] sum_i_next, sum_q_next;

  logic                 cord_start, cord_done;
  logic signed [SW-1:0] cord_phase;
  logic                 div_start, div_done;
  logic signed [TW-1:0] div_dividend, div_quotient;
  logic [fqd_pkg::DIVISOR_W-1:0] div_divisor;
  logic signed [TW-1:0] smooth_num;
  logic [NW-1:0]        smooth_mag;
  logic                 smooth_neg;
  logic [NW+RW-1:0]     smooth_prod;
  logic signed [SW-1:0] smooth_quo;

  logic                 store_we, store_re;
  logic signed [SW-1:0] store_rdata;
  logic                 has_room;
  logic                 out_free;
  logic                 last_read;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == fqd_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign raw_i     = s_tdata[7:0];
  assign raw_q     = s_tdata[15:8];
  assign has_room  = bcount < CW'(MAX_BLOCK_SAMPLES);
  assign out_free  = !m_tvalid || m_tready;
  assign last_read = (rd_idx + 1'b1) == bcount;

  // Quarter-rate rotation by pair position within the block.
  always_comb begin
    bi = raw_i;
    bq = raw_q;
    if (!bypass) begin
      unique case (rot_phase)
        2'd1:    begin bi = fqd_pkg::BYTE_FULL - raw_q; bq = raw_i; end
        2'd2:    begin bi = fqd_pkg::BYTE_FULL - raw_i; bq = fqd_pkg::BYTE_FULL - raw_q; end
        2'd3:    begin bi = raw_q; bq = fqd_pkg::BYTE_FULL - raw_i; end
        default: ;
      endcase
    end
    sum_i_next = sum_i + SW'($signed({1'b0, bi}) - $signed(fqd_pkg::BYTE_CENTRE));
    sum_q_next = sum_q + SW'($signed({1'b0, bq}) - $signed(fqd_pkg::BYTE_CENTRE));
    dcount_inc = dcount + 1'b1;
    closes     = dcount_inc >= factor;
  end

  // Smoothing numerator: average plus nine times the old offset.
  assign smooth_num = TW'(avg) + (TW'(smoothed) <<< 3) + TW'(smoothed);

  // Division by ten on the registered magnitude, sign restored afterwards.
  assign smooth_prod = smooth_mag * fqd_pkg::SMOOTH_RECIP;
  assign smooth_quo  = {1'b0, smooth_prod[fqd_pkg::SMOOTH_SHIFT +: SW-1]};

  // The divider only forms the block average.
  assign div_dividend = btotal;
  assign div_divisor  = bcount;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fqd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cord_start = 1'b0;
    div_start  = 1'b0;
    store_re   = 1'b0;
    unique case (state)
      fqd_pkg::ST_IDLE: begin
        if (accept) begin
          if (closes) state_next = fqd_pkg::ST_PHASE_GO;
          else if (s_tlast) state_next = fqd_pkg::ST_BLOCK_END;
        end
      end
      fqd_pkg::ST_PHASE_GO: begin
        cord_start = 1'b1;
        state_next = fqd_pkg::ST_PHASE_WAIT;
      end
      fqd_pkg::ST_PHASE_WAIT: begin
        if (cord_done) begin
          state_next = eob_hold ? fqd_pkg::ST_BLOCK_END : fqd_pkg::ST_IDLE;
        end
      end
      fqd_pkg::ST_BLOCK_END: begin
        if (bcount == '0) begin
          state_next = fqd_pkg::ST_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = fqd_pkg::ST_AVG_WAIT;
        end
      end
      fqd_pkg::ST_AVG_WAIT: if (div_done) state_next = fqd_pkg::ST_SMOOTH_GO;
      fqd_pkg::ST_SMOOTH_GO: state_next = fqd_pkg::ST_SMOOTH_WAIT;
      fqd_pkg::ST_SMOOTH_WAIT: state_next = fqd_pkg::ST_READ;
      fqd_pkg::ST_READ: begin
        store_re   = 1'b1;
        state_next = fqd_pkg::ST_EMIT;
      end
      fqd_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = last_read ? fqd_pkg::ST_IDLE : fqd_pkg::ST_READ;
        end
      end
      default: state_next = fqd_pkg::ST_IDLE;
    endcase
  end

  assign store_we = (state == fqd_pkg::ST_PHASE_WAIT) && cord_done && has_room;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= fqd_pkg::DEF_DECIMATION;
      bypass <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fqd_pkg::CFG_DECIMATION: factor <= cfg_data;
        fqd_pkg::CFG_BYPASS:     bypass <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Demodulator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_phase     <= '0;
      dcount        <= '0;
      sum_i         <= '0;
      sum_q         <= '0;
      prev_i        <= '0;
      prev_q        <= '0;
      smoothed      <= '0;
      bcount        <= '0;
      btotal        <= '0;
      overflow_seen <= 1'b0;
      eob_hold      <= 1'b0;
      rd_idx        <= '0;
    end else begin
      unique case (state)
        fqd_pkg::ST_IDLE: begin
          if (accept) begin
            rot_phase <= s_tlast ? 2'd0 : rot_phase + 1'b1;
            sum_i     <= sum_i_next;
            sum_q     <= sum_q_next;
            dcount    <= dcount_inc;
            eob_hold  <= s_tlast;
          end
        end
        fqd_pkg::ST_PHASE_WAIT: begin
          if (cord_done) begin
            prev_i <= sum_i;
            prev_q <= sum_q;
            sum_i  <= '0;
            sum_q  <= '0;
            dcount <= '0;
            if (has_room) begin
              bcount <= bcount + 1'b1;
              btotal <= btotal + TW'(cord_phase);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end
        fqd_pkg::ST_BLOCK_END: begin
          rd_idx <= '0;
          if (bcount == '0) begin
            btotal        <= '0;
            overflow_seen <= 1'b0;
          end
        end
        fqd_pkg::ST_EMIT: begin
          if (out_free) begin
            rd_idx <= rd_idx + 1'b1;
            if (last_read) begin
              smoothed      <= offset;
              bcount        <= '0;
              btotal        <= '0;
              overflow_seen <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Block average and smoothed offset.
  always_ff @(posedge clk) begin
    if (div_done && state == fqd_pkg::ST_AVG_WAIT) begin
      avg <= div_quotient[SW-1:0];
    end
    if (state == fqd_pkg::ST_SMOOTH_GO) begin
      smooth_neg <= smooth_num[TW-1];
      smooth_mag <= NW'(smooth_num[TW-1] ? -smooth_num : smooth_num);
    end
    if (state == fqd_pkg::ST_SMOOTH_WAIT) begin
      offset <= smooth_neg ? -smooth_quo : smooth_quo;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == fqd_pkg::ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fqd_pkg::ST_EMIT && out_free) begin
      m_tdata <= 16'(store_rdata - offset);
      m_tlast <= last_read;
      m_tuser <= overflow_seen;
    end
  end

  fqd_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .a_re  (sum_i),
    .a_im  (sum_q),
    .b_re  (prev_i),
    .b_im  (prev_q),
    .done  (cord_done),
    .phase (cord_phase)
  );

  fqd_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  fqd_store #(
    .DEPTH (MAX_BLOCK_SAMPLES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (bcount[AW-1:0]),
    .wdata (cord_phase),
    .re    (store_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (store_rdata)
  );

`ifndef NO_ASSERTIONS
  // The store never holds more samples than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bcount <= CW'(MAX_BLOCK_SAMPLES))
    else $error("block count beyond store size");

  // The phase unit only reports while the sequencer waits for it.
  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cord_done |-> state == fqd_pkg::ST_PHASE_WAIT)
    else $error("phase result outside its wait state");

  // A store read is always followed by the cycle that uses its data.
  a_read_emit: assert property (@(posedge clk) disable iff (rst)
    state == fqd_pkg::ST_READ |=> state == fqd_pkg::ST_EMIT)
    else $error("read data not consumed");

  // A last sample is followed by a return to accepting input.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == fqd_pkg::ST_EMIT && out_free && last_read) |=> state == fqd_pkg::ST_IDLE)
    else $error("sequencer did not return after last sample");
`endif

endmodule
